@@ sv/abna_pkg.sv @@
`default_nettype none

package abna_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 2048;
  localparam int unsigned IMAGE_WIDTH_W  = 12;
  localparam int unsigned IMAGE_WIDTH_REG_W = IMAGE_WIDTH_W + 1;
  localparam int unsigned IMAGE_HEIGHT_W = 16;
  localparam int unsigned CFG_DATA_W     = 16;
  localparam int unsigned CFG_INDEX_W    = 1;
  localparam int unsigned ROW_W          = IMAGE_HEIGHT_W + 1;
  localparam int unsigned PIXEL_W        = 32;
  localparam int unsigned LINE_W         = 2 * PIXEL_W;
  localparam int unsigned SUM_W          = 12;
  localparam int unsigned CNT_W          = 4;
  localparam int unsigned RECIP_SHIFT    = 16;
  localparam int unsigned RECIP_W        = RECIP_SHIFT + 1;
  localparam int unsigned PROD_W         = SUM_W + RECIP_W;

  localparam logic [IMAGE_WIDTH_REG_W-1:0] IMAGE_WIDTH_RST  = 13'd2048;
  localparam logic [IMAGE_HEIGHT_W-1:0]    IMAGE_HEIGHT_RST = 16'd1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
    logic       drain;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       frame_end;
  } pix_out_t;

  // [row slot: 0 newest][column: 2 newest], word = {alpha, blue, green, red}
  typedef logic [2:0][2:0][PIXEL_W-1:0] window_t;
  typedef logic [2:0][2:0]              nbr_mask_t;

  typedef struct packed {
    logic      start;
    nbr_mask_t mask;
  } avg_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } avg_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_SUM,
    ST_AVG,
    ST_OUT
  } abna_state_t;

  // ceil(2^16 / n): floor(s * recip(n) / 2^16) == floor(s / n) for s < 4096
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
    logic [RECIP_W-1:0] r;
    case (n)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13108;
      4'd6:    r = 17'd10923;
      4'd7:    r = 17'd9363;
      4'd8:    r = 17'd8192;
      4'd9:    r = 17'd7282;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/abna_stream_if.sv @@
`default_nettype none

interface abna_in_if
  import abna_pkg::*;
();
  logic    valid;
  logic    ready;
  pix_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface abna_out_if
  import abna_pkg::*;
();
  logic     valid;
  logic     ready;
  pix_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ sv/abna_line_mem.sv @@
`default_nettype none

module abna_line_mem
  import abna_pkg::*;
#(
  parameter int unsigned DEPTH = MAX_WIDTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic      [LINE_W-1:0]          rd_data,
  input  wire logic                       wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  wire logic [LINE_W-1:0]          wr_data
);

  logic [LINE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ sv/abna_avg.sv @@
`default_nettype none

module abna_avg
  import abna_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire avg_req_t req,
  input  wire window_t  win,
  output avg_rsp_t      rsp
);

  logic [2:0][2:0]       opq;
  logic [CNT_W-1:0]      cnt_sum;
  logic [2:0][SUM_W-1:0] chan_sum;

  logic [CNT_W-1:0]      cnt;
  logic [SUM_W-1:0]      sum [3];
  logic [7:0]            rgb [3];
  logic [1:0]            chan;
  logic                  busy;
  logic                  done;
  logic [PROD_W-1:0]     prod;

  always_comb begin
    logic [2:0][CNT_W-1:0]      row_cnt;
    logic [2:0][2:0][SUM_W-1:0] row_sum;
    for (int s = 0; s < 3; s++) begin
      row_cnt[s] = '0;
      row_sum[s] = '0;
      for (int c = 0; c < 3; c++) begin
        opq[s][c] = req.mask[s][c] && (win[s][c][31:24] != 8'd0);
        if (opq[s][c]) begin
          row_cnt[s] = row_cnt[s] + CNT_W'(1);
          for (int k = 0; k < 3; k++) begin
            row_sum[s][k] = row_sum[s][k] + SUM_W'(win[s][c][8*k +: 8]);
          end
        end
      end
    end
    cnt_sum = row_cnt[0] + row_cnt[1] + row_cnt[2];
    for (int k = 0; k < 3; k++) begin
      chan_sum[k] = row_sum[0][k] + row_sum[1][k] + row_sum[2][k];
    end
  end

  assign prod = PROD_W'(sum[chan]) * PROD_W'(recip(cnt));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      chan <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        chan <= '0;
      end else if (busy) begin
        if (chan == 2'd2) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          chan <= chan + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt <= cnt_sum;
      for (int k = 0; k < 3; k++) begin
        sum[k] <= chan_sum[k];
      end
    end else if (busy) begin
      rgb[chan] <= prod[RECIP_SHIFT +: 8];
    end
  end

  assign rsp.done  = done;
  assign rsp.red   = rgb[0];
  assign rsp.green = rgb[1];
  assign rsp.blue  = rgb[2];

endmodule

`default_nettype wire

@@ sv/alpha_bleed_neighbour_average_unit.sv @@
`default_nettype none

// channel     dir  handshake          payload
// pixel_in    in   valid/ready        red_in green_in blue_in alpha_in drain
// pixel_out   out  valid/ready        red_out green_out blue_out alpha_out frame_end
// cfg_*       in   cfg_write          cfg_index (0 width, 1 height), cfg_data
//
// An ignored drain goes no further; others shift and, if they give a result,
// pass sum (and average if transparent) and out; the average runs three passes
// through one reciprocal multiplier. The line memory is read on accept, written
// back in the cycle after. Reset clears counters, window and output valid; the
// line memory is not cleared. A result waits in the output register while the
// next item is accepted; a new result holds until the previous one has left.

module alpha_bleed_neighbour_average_unit
  import abna_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  abna_in_if.sink                     pixel_in,
  abna_out_if.source                  pixel_out
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CW1   = COL_W + 1;
  localparam logic [WW-1:0] W_MIN = WW'(3);
  localparam logic [WW-1:0] W_MAX = WW'(MAX_WIDTH);

  logic [IMAGE_WIDTH_REG_W-1:0] image_width;
  logic [IMAGE_HEIGHT_W-1:0] image_height;
  logic [WW-1:0]             w_eff;
  logic [ROW_W-1:0]          h_ext;

  logic [COL_W-1:0]          column_count;
  logic [ROW_W-1:0]          row_count;

  abna_state_t               state;
  abna_state_t               state_next;

  logic                      flush;
  logic                      take;
  logic                      step;
  logic                      first_col;
  logic                      wrap;
  logic                      emit_now;
  logic                      last_now;
  logic [ROW_W-1:0]          orow_now;
  logic [COL_W-1:0]          ocol_now;

  logic [PIXEL_W-1:0]        pix_q;
  logic [COL_W-1:0]          col_q;
  logic [ROW_W-1:0]          orow_q;
  logic [COL_W-1:0]          ocol_q;
  logic                      emit_q;
  logic                      last_q;

  window_t                   win;
  nbr_mask_t                 mask_q;
  logic [LINE_W-1:0]         line_rd;
  logic [23:0]               res_rgb;

  logic                      shift;
  logic                      centre_opaque;
  logic                      load_out;
  logic                      out_free;
  logic                      out_valid;
  pix_out_t                  out_data;

  avg_req_t                  avg_req;
  avg_rsp_t                  avg_rsp;

  always_comb begin
    if (image_width < IMAGE_WIDTH_REG_W'(3)) begin
      w_eff = W_MIN;
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w_eff = W_MAX;
    end else begin
      w_eff = WW'(image_width);
    end
  end

  assign h_ext = (image_height == '0) ? ROW_W'(1) : ROW_W'(image_height);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMAGE_WIDTH_RST;
      image_height <= IMAGE_HEIGHT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= {1'b0, cfg_data[IMAGE_WIDTH_W-1:0]};
        REG_IMAGE_HEIGHT: image_height <= cfg_data[IMAGE_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  assign flush     = row_count >= h_ext;
  assign take      = pixel_in.valid && pixel_in.ready;
  assign step      = take && !(pixel_in.data.drain && !flush);
  assign first_col = column_count == '0;
  assign wrap      = (CW1'(column_count) + CW1'(1)) >= CW1'(w_eff);
  assign emit_now  = !((row_count == '0) || ((row_count == ROW_W'(1)) && first_col));
  assign last_now  = first_col && (row_count == (h_ext + ROW_W'(1)));
  assign orow_now  = first_col ? (row_count - ROW_W'(2)) : (row_count - ROW_W'(1));
  assign ocol_now  = first_col ? COL_W'(w_eff - WW'(1)) : (column_count - COL_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (cfg_write) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (step) begin
      if (last_now) begin
        column_count <= '0;
        row_count    <= '0;
      end else if (wrap) begin
        column_count <= '0;
        row_count    <= row_count + ROW_W'(1);
      end else begin
        column_count <= column_count + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      pix_q  <= flush ? '0 : {pixel_in.data.alpha_in, pixel_in.data.blue_in,
                              pixel_in.data.green_in, pixel_in.data.red_in};
      col_q  <= column_count;
      orow_q <= orow_now;
      ocol_q <= ocol_now;
      emit_q <= emit_now;
      last_q <= last_now;
    end
  end

  abna_line_mem #(
    .DEPTH (MAX_WIDTH)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (step),
    .rd_addr (column_count),
    .rd_data (line_rd),
    .wr_en   (shift),
    .wr_addr (col_q),
    .wr_data ({line_rd[PIXEL_W-1:0], pix_q})
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (shift) begin
      for (int s = 0; s < 3; s++) begin
        win[s][0] <= win[s][1];
        win[s][1] <= win[s][2];
      end
      win[0][2] <= pix_q;
      win[1][2] <= line_rd[PIXEL_W-1:0];
      win[2][2] <= line_rd[LINE_W-1:PIXEL_W];
    end
  end

  always_ff @(posedge clk) begin
    logic [2:0] row_ok;
    logic [2:0] col_ok;
    row_ok[0] = (orow_q + ROW_W'(1)) < h_ext;
    row_ok[1] = 1'b1;
    row_ok[2] = orow_q != '0;
    col_ok[0] = ocol_q != '0;
    col_ok[1] = 1'b1;
    col_ok[2] = (CW1'(ocol_q) + CW1'(1)) < CW1'(w_eff);
    if (shift) begin
      for (int s = 0; s < 3; s++) begin
        for (int c = 0; c < 3; c++) begin
          mask_q[s][c] <= row_ok[s] && col_ok[c];
        end
      end
    end
  end

  assign centre_opaque = win[1][1][31:24] != 8'd0;
  assign out_free      = !out_valid || pixel_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    pixel_in.ready = 1'b0;
    shift         = 1'b0;
    avg_req.start = 1'b0;
    avg_req.mask  = mask_q;
    load_out      = 1'b0;
    case (state)
      ST_IDLE: begin
        pixel_in.ready = 1'b1;
        if (pixel_in.valid && !(pixel_in.data.drain && !flush)) begin
          state_next = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        shift      = 1'b1;
        state_next = emit_q ? ST_SUM : ST_IDLE;
      end
      ST_SUM: begin
        if (centre_opaque) begin
          state_next = ST_OUT;
        end else begin
          avg_req.start = 1'b1;
          state_next    = ST_AVG;
        end
      end
      ST_AVG: begin
        if (avg_rsp.done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  abna_avg u_avg (
    .clk (clk),
    .rst (rst),
    .req (avg_req),
    .win (win),
    .rsp (avg_rsp)
  );

  always_ff @(posedge clk) begin
    if (state == ST_SUM && centre_opaque) begin
      res_rgb <= win[1][1][23:0];
    end else if (state == ST_AVG && avg_rsp.done) begin
      res_rgb <= {avg_rsp.blue, avg_rsp.green, avg_rsp.red};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (pixel_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data.red_out   <= res_rgb[7:0];
      out_data.green_out <= res_rgb[15:8];
      out_data.blue_out  <= res_rgb[23:16];
      out_data.alpha_out <= win[1][1][31:24];
      out_data.frame_end <= last_q;
    end
  end

  assign pixel_out.valid = out_valid;
  assign pixel_out.data  = out_data;

  a_drain_ignored: assert property (@(posedge clk) disable iff (rst)
    (take && pixel_in.data.drain && !flush && !cfg_write)
      |=> ($stable(column_count) && $stable(row_count)))
    else $error("ignored drain item moved the position counters");

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    CW1'(column_count) < CW1'(w_eff))
    else $error("column count beyond the active width");

  a_last_rewinds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && last_q) |-> (row_count == '0 && column_count == '0))
    else $error("frame end pending without rewound position");

  a_avg_done_waiting: assert property (@(posedge clk) disable iff (rst)
    avg_rsp.done |-> (state == ST_AVG))
    else $error("average finished outside its wait state");

endmodule

`default_nettype wire
